[hdl/ssc_pkg.sv]
`default_nettype none

package ssc_pkg;

  // Request codes on in_req_type
  localparam logic [2:0] REQ_SCAN   = 3'd0;
  localparam logic [2:0] REQ_SCROLL = 3'd1;
  localparam logic [2:0] REQ_BLINK  = 3'd2;
  localparam logic [2:0] REQ_LOAD   = 3'd3;
  localparam logic [2:0] REQ_START  = 3'd4;
  localparam logic [2:0] REQ_EMPTY  = 3'd5;

  // Display modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SCROLL = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;
  localparam logic [1:0] MODE_STATIC = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_MASK      = 2'd1;
  localparam logic [1:0] CFG_SHOW_LAST = 2'd2;

  localparam int CODE_W     = 6;
  localparam int TABLE_SIZE = 39;

  localparam logic [7:0] SEG_TABLE [TABLE_SIZE] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
    8'h40, 8'h08, 8'h80, 8'h00,
    8'h77, 8'h5F, 8'h39, 8'h5E, 8'h79, 8'h7B, 8'h71, 8'h7D, 8'h6F, 8'h76, 8'h74,
    8'h06, 8'h1F, 8'h1E, 8'h06, 8'h38, 8'h37, 8'h3F, 8'h73, 8'hBF, 8'h33, 8'h6D,
    8'h3E, 8'h75, 8'h6E
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic scan_issue;
    logic scan_finish;
    logic scroll_tick;
    logic blink_tick;
    logic load_char;
    logic set_start;
    logic empty_load;
  } cmd_t;

  // Segment pattern of a character code; unknown codes are dark
  function automatic logic [7:0] seg_of(input logic [CODE_W-1:0] code);
    logic [7:0] segs;
    segs = 8'h00;
    if (int'(code) < TABLE_SIZE) begin
      segs = SEG_TABLE[code];
    end
    return segs;
  endfunction

endpackage

`default_nettype wire

[hdl/ssc_ram.sv]
`default_nettype none

module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/ssc_ctrl.sv]
`default_nettype none

module ssc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [2:0]   in_req_type,
  output logic              busy,
  output ssc_pkg::cmd_t     cmd
);

  ssc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode accepted requests; a scan waits in the read state for the store read
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ssc_pkg::ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            ssc_pkg::REQ_SCAN: begin
              cmd.scan_issue = 1'b1;
              state_nxt      = ssc_pkg::ST_READ;
            end
            ssc_pkg::REQ_SCROLL: cmd.scroll_tick = 1'b1;
            ssc_pkg::REQ_BLINK:  cmd.blink_tick  = 1'b1;
            ssc_pkg::REQ_LOAD:   cmd.load_char   = 1'b1;
            ssc_pkg::REQ_START:  cmd.set_start   = 1'b1;
            ssc_pkg::REQ_EMPTY:  cmd.empty_load  = 1'b1;
            default: ;
          endcase
        end
      end
      ssc_pkg::ST_READ: begin
        cmd.scan_finish = 1'b1;
        state_nxt       = ssc_pkg::ST_IDLE;
      end
      default: state_nxt = ssc_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r == ssc_pkg::ST_READ);

endmodule

`default_nettype wire

[hdl/ssc_datapath.sv]
`default_nettype none

module ssc_datapath #(
  parameter int DIGIT_COUNT = 4,
  parameter int STORE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ssc_pkg::cmd_t cmd,
  input  wire logic [5:0]   in_char_code,
  input  wire logic         in_first_char,
  input  wire logic         in_last_char,
  input  wire logic [3:0]   in_start_index,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [3:0]   cfg_data,
  output logic              out_strobe,
  output logic [1:0]        out_digit_select,
  output logic [7:0]        out_segments
);

  localparam int LW  = $clog2(STORE_DEPTH + 1);
  localparam int WSW = $clog2(STORE_DEPTH);
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int IW  = LW + 1;
  localparam int DW  = ($clog2(DIGIT_COUNT) < 2) ? 2 : $clog2(DIGIT_COUNT);
  // Largest quotient of scroll position plus digit over the scroll modulus
  localparam int QMAX = (STORE_DEPTH + DIGIT_COUNT - 1) / (DIGIT_COUNT + 2);
  localparam int QW   = $clog2(QMAX + 1);
  localparam int RW   = IW + QW;

  logic [LW-1:0]  len_r, len_nxt;
  logic [WSW-1:0] ws_r, ws_nxt;
  logic [LW-1:0]  pos_r, pos_nxt;
  logic [DW-1:0]  digit_r, digit_nxt;
  logic           phase_r, phase_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [3:0]     mask_r, mask_nxt;
  logic           show_last_r, show_last_nxt;
  logic           blank_r, blank_nxt;
  logic [1:0]     dsel_r, dsel_nxt;
  logic           strobe_r, strobe_nxt;
  logic [7:0]     segs_r, segs_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [5:0]     ram_rdata;
  logic [IW-1:0]  idx;
  logic [RW-1:0]  sum;
  logic [RW-1:0]  modulus;
  logic [LW-1:0]  len_load;

  // Window on the last characters of a message of a given length
  function automatic logic [WSW-1:0] last_window(input logic [LW-1:0] len);
    logic [WSW-1:0] ws;
    ws = '0;
    if (int'(len) > DIGIT_COUNT) begin
      ws = WSW'(int'(len) - DIGIT_COUNT);
    end
    return ws;
  endfunction

  ssc_ram #(
    .WIDTH (ssc_pkg::CODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_char_code),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Store index of the scanned digit; reduce the scroll sum by shifted moduli
  always_comb begin
    modulus = RW'(len_r) + RW'(1);
    sum     = RW'(pos_r) + RW'(digit_r);
    for (int k = QW - 1; k >= 0; k--) begin
      if (sum >= (modulus << k)) begin
        sum = sum - (modulus << k);
      end
    end
    if (mode_r == ssc_pkg::MODE_SCROLL) begin
      idx = (int'(len_r) <= DIGIT_COUNT) ? IW'(digit_r) : IW'(sum);
    end else begin
      idx = IW'(ws_r) + IW'(digit_r);
    end
  end

  assign ram_raddr = idx[AW-1:0];

  // Length after a possible new-message clear
  assign len_load = in_first_char ? '0 : len_r;
  assign ram_we   = cmd.load_char && (int'(len_load) < STORE_DEPTH);
  assign ram_waddr = len_load[AW-1:0];

  // Next state of the display registers
  always_comb begin
    len_nxt       = len_r;
    ws_nxt        = ws_r;
    pos_nxt       = pos_r;
    digit_nxt     = digit_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    mask_nxt      = mask_r;
    show_last_nxt = show_last_r;
    blank_nxt     = blank_r;
    dsel_nxt      = dsel_r;
    strobe_nxt    = 1'b0;
    segs_nxt      = segs_r;

    // Scan: latch the blanking decision, advance the digit; clear mode also empties the message
    if (cmd.scan_issue) begin
      dsel_nxt  = digit_r[1:0];
      blank_nxt = (idx >= IW'(len_r));
      if (mode_r == ssc_pkg::MODE_CLEAR) begin
        blank_nxt = 1'b1;
        len_nxt   = '0;
        ws_nxt    = '0;
      end else if (mode_r == ssc_pkg::MODE_BLINK && phase_r &&
                   int'(digit_r) < 4 && mask_r[digit_r[1:0]]) begin
        blank_nxt = 1'b1;
      end
      digit_nxt = (int'(digit_r) + 1 >= DIGIT_COUNT) ? '0 : digit_r + DW'(1);
    end

    // Scan finish: look up the character read from the store
    if (cmd.scan_finish) begin
      strobe_nxt = 1'b1;
      segs_nxt   = blank_r ? 8'h00 : ssc_pkg::seg_of(ram_rdata);
    end

    if (cmd.scroll_tick && mode_r == ssc_pkg::MODE_SCROLL) begin
      pos_nxt = (pos_r >= len_r) ? '0 : pos_r + LW'(1);
    end

    if (cmd.blink_tick && mode_r == ssc_pkg::MODE_BLINK) begin
      phase_nxt = ~phase_r;
    end

    // Load one character
    if (cmd.load_char) begin
      len_nxt = len_load;
      if (in_first_char) begin
        ws_nxt = '0;
      end
      if (int'(len_load) < STORE_DEPTH) begin
        len_nxt = len_load + LW'(1);
      end
      if (in_last_char && show_last_r) begin
        ws_nxt = last_window(len_nxt);
      end
    end

    if (cmd.set_start && int'(in_start_index) < STORE_DEPTH - DIGIT_COUNT) begin
      ws_nxt = WSW'(in_start_index);
    end

    if (cmd.empty_load) begin
      len_nxt = '0;
      ws_nxt  = '0;
    end

    // Register writes
    if (cfg_we) begin
      case (cfg_addr)
        ssc_pkg::CFG_MODE: begin
          mode_nxt = cfg_data[1:0];
          if (cfg_data[1:0] != mode_r) begin
            pos_nxt   = '0;
            phase_nxt = 1'b0;
          end
        end
        ssc_pkg::CFG_MASK: mask_nxt = cfg_data;
        ssc_pkg::CFG_SHOW_LAST: begin
          show_last_nxt = cfg_data[0];
          if (cfg_data[0]) begin
            ws_nxt = last_window(len_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ws_r        <= '0;
      pos_r       <= '0;
      digit_r     <= '0;
      phase_r     <= 1'b0;
      mode_r      <= ssc_pkg::MODE_CLEAR;
      mask_r      <= '0;
      show_last_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ws_r        <= ws_nxt;
      pos_r       <= pos_nxt;
      digit_r     <= digit_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      mask_r      <= mask_nxt;
      show_last_r <= show_last_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blank_r <= blank_nxt;
    dsel_r  <= dsel_nxt;
    segs_r  <= segs_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_digit_select = dsel_r;
  assign out_segments     = segs_r;

endmodule

`default_nettype wire

[hdl/seven_segment_scan_controller.sv]
`default_nettype none

// Four-digit multiplexed seven-segment scan controller. Issue a request with
// start while busy is low. A scan tick (req_type 0) holds busy for one cycle
// while the character store is read and yields one result on out_strobe,
// registered after the read state; a scan waits on the registered read of the
// store RAM. All other requests complete in the cycle of their transfer, give
// no result and leave busy low. Results are shown for one cycle only and the
// receiver cannot stall them. Configuration writes are always ready and take
// effect in the cycle after the write. Stored characters past the message
// length read as blank through the length count, so reset needs no sweep of
// the store.
module seven_segment_scan_controller #(
  parameter int DIGIT_COUNT = 4,
  parameter int STORE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_req_type,
  input  wire logic [5:0] in_char_code,
  input  wire logic       in_first_char,
  input  wire logic       in_last_char,
  input  wire logic [3:0] in_start_index,
  output logic            out_strobe,
  output logic [1:0]      out_digit_select,
  output logic [7:0]      out_segments,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [3:0] cfg_data
);

  ssc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  ssc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .busy        (busy),
    .cmd         (cmd)
  );

  ssc_datapath #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_char_code     (in_char_code),
    .in_first_char    (in_first_char),
    .in_last_char     (in_last_char),
    .in_start_index   (in_start_index),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_digit_select (out_digit_select),
    .out_segments     (out_segments)
  );

`ifndef SYNTHESIS
  // A scan transfer makes the block busy for its store read
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == ssc_pkg::REQ_SCAN |=> busy)
    else $error("scan transfer did not raise busy");

  // The busy phase lasts one cycle
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // Each result follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("scan finished without a result");

  // No result without a preceding scan
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result strobe without a scan");
`endif

endmodule

`default_nettype wire
